// ===== hdl/pic_pkg.sv =====
// Package for the pad induced charge block: item types, lane types, constants.
// Holds the arctangent table and the pipeline depths used by the corner lane and the top.
// No dependencies.
package pic_pkg;

  // Fixed point format and iteration counts.
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 18;
  localparam int SQRT_STEPS   = 32;
  localparam int STEP_W       = 5;

  // Datapath widths.
  localparam int CW     = 62;  // CORDIC x and y
  localparam int ZW     = 32;  // angle in Q30
  localparam int SW     = 35;  // sum of four angles
  localparam int NORM_W = 58;  // normalized operands, top bit at NORM_TOP
  localparam logic [5:0] NORM_TOP = 6'd57;

  // 1/(2*pi) in Q32.
  localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;

  // Pipeline depths.
  localparam int FLAG_LAT    = SQRT_STEPS + 4 + CORDIC_STEPS;
  localparam int LANE_LAT    = FLAG_LAT + 2;
  localparam int PIC_LATENCY = LANE_LAT + 5;

  // Register index of the configuration port.
  localparam logic REG_INDUCTION_FACTOR = 1'b0;

  typedef struct packed {
    logic signed [31:0] point_charge;
    logic signed [31:0] plane_distance;
    logic signed [31:0] x_low;
    logic signed [31:0] y_low;
    logic signed [31:0] x_high;
    logic signed [31:0] y_high;
  } pic_in_t;

  typedef struct packed {
    logic signed [31:0] induced_charge;
    logic               bad_geometry;
  } pic_out_t;

  // Operands of one corner lane.
  typedef struct packed {
    logic [31:0] ud;
    logic [31:0] ux;
    logic [31:0] uy;
    logic [63:0] sq_d;
    logic [63:0] sq_x;
    logic [63:0] sq_y;
    logic        neg;
  } corner_in_t;

  // State handed from one square root cell to the next.
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sqrt_t;

  // State handed from one CORDIC cell to the next.
  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic [ZW-1:0]        z;
  } cordic_t;

  // Per-item data that travels beside the corner lanes.
  typedef struct packed {
    logic        bad;
    logic        fneg;
    logic [62:0] fmag;
  } side_t;

  // Rounded atan(2^-i) in Q30.
  function automatic logic [ZW-1:0] atan_q30(input logic [STEP_W-1:0] i);
    logic [ZW-1:0] a;
    case (i)
      5'd0:  a = 32'd843314857;
      5'd1:  a = 32'd497837830;
      5'd2:  a = 32'd263043837;
      5'd3:  a = 32'd133525159;
      5'd4:  a = 32'd67021687;
      5'd5:  a = 32'd33543516;
      5'd6:  a = 32'd16775851;
      5'd7:  a = 32'd8388438;
      5'd8:  a = 32'd4194283;
      5'd9:  a = 32'd2097150;
      5'd10: a = 32'd1048576;
      5'd11: a = 32'd524288;
      5'd12: a = 32'd262144;
      5'd13: a = 32'd131072;
      5'd14: a = 32'd65536;
      5'd15: a = 32'd32768;
      5'd16: a = 32'd16384;
      5'd17: a = 32'd8192;
      5'd18: a = 32'd4096;
      5'd19: a = 32'd2048;
      5'd20: a = 32'd1024;
      5'd21: a = 32'd512;
      5'd22: a = 32'd256;
      5'd23: a = 32'd128;
      5'd24: a = 32'd64;
      5'd25: a = 32'd32;
      5'd26: a = 32'd16;
      5'd27: a = 32'd8;
      5'd28: a = 32'd4;
      5'd29: a = 32'd2;
      5'd30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // Magnitude of a signed 32-bit value as unsigned.
  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

// ===== hdl/pic_sqrt_cell.sv =====
// One cell of the integer square root chain: resolves one root bit per item.
// Depends on pic_pkg.
module pic_sqrt_cell import pic_pkg::*; (
  input  logic              clk,
  input  logic [STEP_W-1:0] step,
  input  sqrt_t             d_in,
  output sqrt_t             d_out
);

  logic [63:0] bitv;
  logic [63:0] trial;
  sqrt_t       d_nxt;
  sqrt_t       d_r;

  // Trial subtraction of the current root bit.
  always_comb begin
    bitv  = 64'd1 << (7'd62 - {1'b0, step, 1'b0});
    trial = d_in.root + bitv;
    if (d_in.rem >= trial) begin
      d_nxt.rem  = d_in.rem - trial;
      d_nxt.root = (d_in.root >> 1) + bitv;
    end else begin
      d_nxt.rem  = d_in.rem;
      d_nxt.root = d_in.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d_out = d_r;

endmodule

// ===== hdl/pic_cordic_cell.sv =====
// One vectoring CORDIC cell: one rotation toward the x axis per item.
// Depends on pic_pkg for the cell state type and the arctangent table.
module pic_cordic_cell import pic_pkg::*; (
  input  logic              clk,
  input  logic [STEP_W-1:0] step,
  input  cordic_t           d_in,
  output cordic_t           d_out
);

  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic signed [CW-1:0] sx;
  logic signed [CW-1:0] sy;
  cordic_t              d_nxt;
  cordic_t              d_r;

  // Rotate by the sign of y; shifts floor.
  always_comb begin
    cx = d_in.cx;
    cy = d_in.cy;
    sx = cx >>> step;
    sy = cy >>> step;
    if (!cy[CW-1]) begin
      d_nxt.cx = cx + sy;
      d_nxt.cy = cy - sx;
      d_nxt.z  = d_in.z + atan_q30(step);
    end else begin
      d_nxt.cx = cx - sy;
      d_nxt.cy = cy + sx;
      d_nxt.z  = d_in.z - atan_q30(step);
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d_out = d_r;

endmodule

// ===== hdl/pic_corner.sv =====
// One corner lane: square root, normalization and CORDIC arctangent.
// Depends on pic_pkg, pic_sqrt_cell and pic_cordic_cell.
module pic_corner import pic_pkg::*; (
  input  logic          clk,
  input  corner_in_t    cin,
  output logic [ZW-1:0] angle
);

  // Entry stage: radius squared and the numerator.
  logic [63:0] sum_r;
  logic [63:0] num_r;
  logic [31:0] ud_r;
  logic        flag_r;

  always_ff @(posedge clk) begin
    sum_r  <= cin.sq_d + cin.sq_x + cin.sq_y;
    num_r  <= {32'd0, cin.ux} * {32'd0, cin.uy};
    ud_r   <= cin.ud;
    flag_r <= cin.neg;
  end

  // Square root chain.
  sqrt_t sq [SQRT_STEPS+1];
  assign sq[0] = '{rem: sum_r, root: 64'd0};

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    pic_sqrt_cell u_cell (
      .clk   (clk),
      .step  (STEP_W'(k)),
      .d_in  (sq[k]),
      .d_out (sq[k+1])
    );
  end

  // Numerator and distance ride beside the root chain.
  logic [63:0] snum_r [SQRT_STEPS];
  logic [31:0] sud_r  [SQRT_STEPS];

  always_ff @(posedge clk) begin
    snum_r[0] <= num_r;
    sud_r[0]  <= ud_r;
    for (int i = 1; i < SQRT_STEPS; i++) begin
      snum_r[i] <= snum_r[i-1];
      sud_r[i]  <= sud_r[i-1];
    end
  end

  // The quadrant sign rides beside the whole lane.
  logic fl_r [FLAG_LAT];

  always_ff @(posedge clk) begin
    fl_r[0] <= flag_r;
    for (int i = 1; i < FLAG_LAT; i++) begin
      fl_r[i] <= fl_r[i-1];
    end
  end

  // Denominator d * r.
  logic [63:0] den_r;
  logic [63:0] numd_r;

  always_ff @(posedge clk) begin
    den_r  <= {32'd0, sud_r[SQRT_STEPS-1]} * {32'd0, sq[SQRT_STEPS].root[31:0]};
    numd_r <= snum_r[SQRT_STEPS-1];
  end

  // Leading one search, first pass: per byte of the larger operand.
  logic [63:0] mx;
  logic [7:0]  gany;
  logic [2:0]  gpos [8];
  logic [7:0]  gany_r;
  logic [2:0]  gpos_r [8];
  logic [63:0] numa_r;
  logic [63:0] dena_r;

  always_comb begin
    mx = (numd_r > den_r) ? numd_r : den_r;
    for (int g = 0; g < 8; g++) begin
      gany[g] = |mx[8*g +: 8];
      gpos[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (mx[8*g + b]) begin
          gpos[g] = 3'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    gany_r <= gany;
    gpos_r <= gpos;
    numa_r <= numd_r;
    dena_r <= den_r;
  end

  // Leading one search, second pass: pick the top byte.
  logic [5:0]  p;
  logic [5:0]  p_r;
  logic [63:0] numb_r;
  logic [63:0] denb_r;

  always_comb begin
    p = 6'd0;
    for (int g = 0; g < 8; g++) begin
      if (gany_r[g]) begin
        p = {3'(g), gpos_r[g]};
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= p;
    numb_r <= numa_r;
    denb_r <= dena_r;
  end

  // Shift both operands so the larger has its top bit at NORM_TOP.
  logic [63:0]       nums;
  logic [63:0]       dens;
  logic [NORM_W-1:0] numc_r;
  logic [NORM_W-1:0] denc_r;

  always_comb begin
    if (p_r > NORM_TOP) begin
      nums = numb_r >> (p_r - NORM_TOP);
      dens = denb_r >> (p_r - NORM_TOP);
    end else begin
      nums = numb_r << (NORM_TOP - p_r);
      dens = denb_r << (NORM_TOP - p_r);
    end
  end

  always_ff @(posedge clk) begin
    numc_r <= nums[NORM_W-1:0];
    denc_r <= dens[NORM_W-1:0];
  end

  // The normalized numerator can shift down to zero; that flag rides beside the CORDIC.
  logic nz_r [CORDIC_STEPS];

  always_ff @(posedge clk) begin
    nz_r[0] <= (numc_r != '0);
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      nz_r[i] <= nz_r[i-1];
    end
  end

  // CORDIC chain.
  cordic_t cd [CORDIC_STEPS+1];
  assign cd[0] = '{cx: {{(CW-NORM_W){1'b0}}, denc_r},
                   cy: {{(CW-NORM_W){1'b0}}, numc_r},
                   z:  {ZW{1'b0}}};

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
    pic_cordic_cell u_cell (
      .clk   (clk),
      .step  (STEP_W'(j)),
      .d_in  (cd[j]),
      .d_out (cd[j+1])
    );
  end

  // Apply the quadrant sign when the numerator is nonzero.
  logic [ZW-1:0] angle_r;

  always_ff @(posedge clk) begin
    if (fl_r[FLAG_LAT-1] && nz_r[CORDIC_STEPS-1]) begin
      angle_r <= -cd[CORDIC_STEPS].z;
    end else begin
      angle_r <= cd[CORDIC_STEPS].z;
    end
  end

  assign angle = angle_r;

endmodule

// ===== hdl/pad_induced_charge.sv =====
// Pad induced charge: fully pipelined, one item accepted per clock, busy stays low.
// The pipeline depth from accept to out_valid is set mostly by the
// 32 square root cells and the CORDIC_STEPS CORDIC cells of each corner lane.
// Throughput is one item per cycle; results are shown for one cycle and cannot stall.
// Synchronous active low reset clears the valid line and the induction factor to 0.
// Depends on pic_pkg and pic_corner.
module pad_induced_charge import pic_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  pic_in_t     in_item,
  output logic        out_valid,
  output pic_out_t    out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic accept;
  logic cfg_wr;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration register.
  logic [31:0] factor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= 32'd0;
    end else if (cfg_wr && (paddr[2] == REG_INDUCTION_FACTOR)) begin
      factor_r <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_INDUCTION_FACTOR) ? factor_r : 32'd0;

  // Input register.
  pic_in_t in_r;
  logic    v0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
    if (accept) begin
      in_r <= in_item;
    end
  end

  // Magnitudes, squares and the scaled charge.
  logic [31:0]        mxl, mxh, myl, myh;
  logic signed [63:0] fc;
  logic [31:0]        ud_r, uxl_r, uxh_r, uyl_r, uyh_r;
  logic [63:0]        sqd_r, sqxl_r, sqxh_r, sqyl_r, sqyh_r;
  logic               sxl_r, sxh_r, syl_r, syh_r;
  side_t              side1_r;
  logic               v1_r;

  always_comb begin
    mxl = mag32(in_r.x_low);
    mxh = mag32(in_r.x_high);
    myl = mag32(in_r.y_low);
    myh = mag32(in_r.y_high);
    fc  = $signed(factor_r) * in_r.point_charge;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
    ud_r   <= in_r.plane_distance;
    uxl_r  <= mxl;
    uxh_r  <= mxh;
    uyl_r  <= myl;
    uyh_r  <= myh;
    sqd_r  <= {32'd0, in_r.plane_distance} * {32'd0, in_r.plane_distance};
    sqxl_r <= {32'd0, mxl} * {32'd0, mxl};
    sqxh_r <= {32'd0, mxh} * {32'd0, mxh};
    sqyl_r <= {32'd0, myl} * {32'd0, myl};
    sqyh_r <= {32'd0, myh} * {32'd0, myh};
    sxl_r  <= in_r.x_low[31];
    sxh_r  <= in_r.x_high[31];
    syl_r  <= in_r.y_low[31];
    syh_r  <= in_r.y_high[31];
    side1_r.bad  <= in_r.plane_distance[31] || (in_r.plane_distance == 32'sd0);
    side1_r.fneg <= fc[63];
    side1_r.fmag <= fc[63] ? (-fc[62:0]) : fc[62:0];
  end

  // Four corner lanes: (xl,yl) (xl,yh) (xh,yh) (xh,yl).
  corner_in_t    cin [4];
  logic [ZW-1:0] ang [4];

  assign cin[0] = '{ud: ud_r, ux: uxl_r, uy: uyl_r, sq_d: sqd_r, sq_x: sqxl_r,
                    sq_y: sqyl_r, neg: sxl_r ^ syl_r};
  assign cin[1] = '{ud: ud_r, ux: uxl_r, uy: uyh_r, sq_d: sqd_r, sq_x: sqxl_r,
                    sq_y: sqyh_r, neg: sxl_r ^ syh_r};
  assign cin[2] = '{ud: ud_r, ux: uxh_r, uy: uyh_r, sq_d: sqd_r, sq_x: sqxh_r,
                    sq_y: sqyh_r, neg: sxh_r ^ syh_r};
  assign cin[3] = '{ud: ud_r, ux: uxh_r, uy: uyl_r, sq_d: sqd_r, sq_x: sqxh_r,
                    sq_y: sqyl_r, neg: sxh_r ^ syl_r};

  for (genvar c = 0; c < 4; c++) begin : g_corner
    pic_corner u_corner (
      .clk   (clk),
      .cin   (cin[c]),
      .angle (ang[c])
    );
  end

  // Valid bits and side data beside the lanes.
  logic [LANE_LAT-1:0] vl_r;
  side_t               sd_r [LANE_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r <= '0;
    end else begin
      vl_r <= {vl_r[LANE_LAT-2:0], v1_r};
    end
    sd_r[0] <= side1_r;
    for (int i = 1; i < LANE_LAT; i++) begin
      sd_r[i] <= sd_r[i-1];
    end
  end

  // Signed sum of the four corner angles.
  logic [SW-1:0] s_r;
  side_t         sp1_r;
  logic          vp1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp1_r <= 1'b0;
    end else begin
      vp1_r <= vl_r[LANE_LAT-1];
    end
    s_r <= {{(SW-ZW){ang[0][ZW-1]}}, ang[0]} - {{(SW-ZW){ang[1][ZW-1]}}, ang[1]}
         + {{(SW-ZW){ang[2][ZW-1]}}, ang[2]} - {{(SW-ZW){ang[3][ZW-1]}}, ang[3]};
    sp1_r <= sd_r[LANE_LAT-1];
  end

  // Ratio q = |sum| / (2*pi).
  logic [SW-1:0] sabs;
  logic [63:0]   qprod;
  logic [31:0]   q_r;
  logic          neg2_r;
  logic          bad2_r;
  logic [62:0]   fmag2_r;
  logic          vp2_r;

  always_comb begin
    sabs  = s_r[SW-1] ? (-s_r) : s_r;
    qprod = {{(64-(SW-1)){1'b0}}, sabs[SW-2:0]} * {32'd0, INV_TWO_PI_Q32};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp2_r <= 1'b0;
    end else begin
      vp2_r <= vp1_r;
    end
    q_r     <= qprod[63:32];
    neg2_r  <= sp1_r.fneg != s_r[SW-1];
    bad2_r  <= sp1_r.bad;
    fmag2_r <= sp1_r.fmag;
  end

  // Partial products of |factor*charge| and q.
  logic [63:0] lprod;
  logic [63:0] hi_r;
  logic [31:0] lo_r;
  logic        neg3_r;
  logic        bad3_r;
  logic        vp3_r;

  assign lprod = {32'd0, fmag2_r[31:0]} * {32'd0, q_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp3_r <= 1'b0;
    end else begin
      vp3_r <= vp2_r;
    end
    hi_r   <= {33'd0, fmag2_r[62:32]} * {32'd0, q_r};
    lo_r   <= lprod[63:32];
    neg3_r <= neg2_r;
    bad3_r <= bad2_r;
  end

  // Final scale, sign and saturation.
  logic [63:0] t;
  logic [63:0] tsh;
  logic [63:0] tneg;
  logic [31:0] res;
  pic_out_t    out_nxt;
  pic_out_t    out_r;
  logic        out_valid_r;

  always_comb begin
    t    = hi_r + {32'd0, lo_r};
    tsh  = t >> (FRAC_BITS - 2);
    tneg = -tsh;
    if (neg3_r) begin
      res = (tsh > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : tneg[31:0];
    end else begin
      res = (tsh > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : tsh[31:0];
    end
    if (bad3_r) begin
      out_nxt.induced_charge = 32'sd0;
      out_nxt.bad_geometry   = 1'b1;
    end else begin
      out_nxt.induced_charge = res;
      out_nxt.bad_geometry   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vp3_r;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // A result appears exactly the pipeline depth after its item was taken.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(start && !busy && rst_n, PIC_LATENCY + 1))
    else $error("result strobe does not match an accepted item");

  // A bad geometry result always carries zero charge.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.bad_geometry) |-> (out_item.induced_charge == 32'sd0))
    else $error("bad geometry result with nonzero charge");

  // A write to the factor register lands on the next edge.
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && (paddr[2] == REG_INDUCTION_FACTOR)) |=> (factor_r == $past(pwdata)))
    else $error("induction factor write lost");

endmodule

// ===== tb/pad_induced_charge_tb.sv =====
// Testbench for pad_induced_charge: random and directed pad geometries, checked against
// a bit-exact fixed point predictor of the four-corner arctangent sum held in a small class.
// Depends on pic_pkg and the pad_induced_charge RTL.
module pad_induced_charge_tb import pic_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam int ADDR_FACTOR = 0;
  localparam int ADDR_UNUSED = 4;

  // Predicts the induced charge of each accepted item and checks results in order.
  class induced_charge_book;
    logic signed [31:0] factor;
    pic_out_t expected_charges[$];
    int mismatches;
    int checked;

    function new();
      factor = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    function logic [63:0] magnitude(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
        if (v >= res + bit_w) begin
          v -= res + bit_w;
          res = (res >> 1) + bit_w;
        end else begin
          res >>= 1;
        end
        bit_w >>= 2;
      end
      return res;
    endfunction

    // Angle of one corner in Q30, the ratio done by a vectoring CORDIC.
    function longint corner_q30(longint d, longint x, longint y);
      logic [63:0] ux, uy, ud, r, num, den, mx;
      int p;
      longint cx, cy, nx, z;
      ux = magnitude(x);
      uy = magnitude(y);
      ud = 64'(d);
      r = floor_sqrt(ud * ud + ux * ux + uy * uy);
      num = ux * uy;
      den = ud * r;
      mx = num > den ? num : den;
      p = 0;
      while (p < 63 && (mx >> (p + 1)) != 0) p++;
      if (p > 57) begin
        num >>= (p - 57);
        den >>= (p - 57);
      end else begin
        num <<= (57 - p);
        den <<= (57 - p);
      end
      cx = longint'(den);
      cy = longint'(num);
      z = 0;
      for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
        if (cy >= 0) begin
          nx = cx + (cy >>> i);
          cy = cy - (cx >>> i);
          z += longint'(atan_q30(STEP_W'(i)));
        end else begin
          nx = cx - (cy >>> i);
          cy = cy + (cx >>> i);
          z -= longint'(atan_q30(STEP_W'(i)));
        end
        cx = nx;
      end
      if (num != 0 && ((x < 0) != (y < 0))) z = -z;
      return z;
    endfunction

    function void note_item(pic_in_t it);
      pic_out_t e;
      longint d, s, fc;
      logic [63:0] q, m, t;
      logic neg;
      d = longint'(it.plane_distance);
      if (d <= 0) begin
        e.induced_charge = '0;
        e.bad_geometry = 1'b1;
      end else begin
        s = corner_q30(d, it.x_low, it.y_low) - corner_q30(d, it.x_low, it.y_high)
          + corner_q30(d, it.x_high, it.y_high) - corner_q30(d, it.x_high, it.y_low);
        q = (magnitude(s) * 64'(INV_TWO_PI_Q32)) >> 32;
        fc = longint'(factor) * longint'(it.point_charge);
        m = magnitude(fc);
        neg = (fc < 0) != (s < 0);
        t = (m >> 32) * q + (((m & 64'hFFFF_FFFF) * q) >> 32);
        t >>= (FRAC_BITS - 2);
        if (neg) e.induced_charge = t > 64'h8000_0000 ? 32'h8000_0000 : 32'(-t);
        else e.induced_charge = t > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : 32'(t);
        e.bad_geometry = 1'b0;
      end
      expected_charges.push_back(e);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(pic_out_t got);
      pic_out_t e;
      if (expected_charges.size() == 0) begin
        report("result with no item outstanding");
        return;
      end
      e = expected_charges.pop_front();
      checked++;
      if (got.induced_charge !== e.induced_charge)
        report($sformatf("induced_charge %h, predicted %h", got.induced_charge,
                         e.induced_charge));
      if (got.bad_geometry !== e.bad_geometry)
        report($sformatf("bad_geometry %b, predicted %b", got.bad_geometry,
                         e.bad_geometry));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  pic_in_t in_item = '0;
  logic out_valid;
  pic_out_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  induced_charge_book book = new();
  int quiet_cycles = 0;
  bit may_idle = 1'b1;
  int bad_count = 0;

  pad_induced_charge dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Note accepted items, check results, and watch for a stalled run.
  always @(posedge clk) begin
    bit seen;
    seen = 1'b0;
    if (rst_n) begin
      if (start && !busy) begin
        book.note_item(in_item);
        if (in_item.plane_distance <= 0) bad_count <= bad_count + 1;
        seen = 1'b1;
      end
      if (out_valid) begin
        book.check_result(out_item);
        seen = 1'b1;
      end
      if (psel && penable && pready) seen = 1'b1;
      quiet_cycles <= seen ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("timeout: no traffic for %0d cycles", IDLE_LIMIT);
        $display("[pad_induced_charge] ERROR");
        $finish;
      end
    end
  end

  // Presents one item, with an occasional gap ahead of it; called just after a falling edge.
  task automatic send(pic_in_t it);
    if (may_idle && $urandom_range(99) < 5) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Writes a register, then reads back the induction factor.
  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    start <= 1'b0;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_FACTOR) book.factor = value;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= 3'(ADDR_FACTOR);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== book.factor)
      book.report($sformatf("factor reads %h, written %h", prdata, book.factor));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Lets every outstanding result arrive, then the pipeline settle.
  task automatic drain();
    start <= 1'b0;
    while (book.expected_charges.size() != 0) @(negedge clk);
    repeat (PIC_LATENCY + 5) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value(bit narrow);
    case ($urandom_range(9))
      0: return 32'h8000_0000 + $urandom_range(2);
      1: return 32'h7FFF_FFFF - $urandom_range(2);
      2: return $urandom;
      default:
        return narrow ? 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000 : $urandom;
    endcase
  endfunction

  function automatic pic_in_t random_item();
    pic_in_t it;
    bit narrow;
    narrow = $urandom_range(3) != 0;
    it.point_charge = pick_value(narrow);
    if ($urandom_range(19) == 0)
      it.plane_distance = 32'(-$signed({1'b0, $urandom_range(0, 99)}));
    else if (narrow) it.plane_distance = $urandom_range(1, 32'h0010_0000);
    else it.plane_distance = $urandom;
    it.x_low = pick_value(narrow);
    it.y_low = pick_value(narrow);
    it.x_high = pick_value(narrow);
    it.y_high = pick_value(narrow);
    return it;
  endfunction

  function automatic pic_in_t geom(logic [31:0] qc, logic [31:0] d, logic [31:0] xl,
                                   logic [31:0] yl, logic [31:0] xh, logic [31:0] yh);
    pic_in_t it;
    it = '{qc, d, xl, yl, xh, yh};
    return it;
  endfunction

  initial begin
    logic [31:0] factors[5];
    factors = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000};
    factors[4] = $urandom;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset value of the factor gives zero charge; the write to an unused address is dropped.
    send(geom(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000,
              32'h0001_0000, 32'h0001_0000));
    drain();
    write_reg(3'(ADDR_UNUSED), 32'h1234_5678);

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(3'(ADDR_FACTOR), factors[ph]);
      may_idle = ph != 2;
      if (ph == 0 || ph == 1 || ph == 2) begin
        // Geometry corners: non-positive distance, edges on the axes, extreme fields.
        send(geom(32'h0001_0000, 32'h0000_0000, 32'hFFFF_0000, 32'hFFFF_0000,
                  32'h0001_0000, 32'h0001_0000));
        send(geom(32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
                  32'h0001_0000, 32'h0001_0000));
        send(geom(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h8000_0000));
        send(geom(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000,
                  32'h0001_0000, 32'h0001_0000));
        send(geom(32'h0002_0000, 32'h0000_8000, 32'h0000_0000, 32'h0000_0000,
                  32'h0003_0000, 32'h0002_0000));
        send(geom(32'hFFFE_0000, 32'h0000_0001, 32'hFFFD_0000, 32'h0000_0000,
                  32'h0000_0000, 32'h0004_0000));
        send(geom(32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send(geom(32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send(geom(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send(geom(32'h0001_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0001,
                  32'h0000_0002, 32'h0000_0002));
        send(geom(32'h0001_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001,
                  32'h0000_0002, 32'hFFFF_FFFE));
        send(geom(32'hFFFF_FFFF, 32'h0010_0000, 32'h0005_0000, 32'hFFFB_0000,
                  32'hFFFB_0000, 32'h0005_0000));
        send(geom(32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000,
                  32'h0001_0000, 32'h0001_0000));
      end
      repeat (200) send(random_item());
      drain();
    end

    $display("covered %0d results over five factor settings, %0d with bad geometry",
             book.checked, bad_count);
    if (book.mismatches == 0 && book.expected_charges.size() == 0) begin
      $display("[pad_induced_charge] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", book.mismatches,
               book.expected_charges.size());
      $display("[pad_induced_charge] ERROR");
    end
    $finish;
  end
endmodule
